### hw/rtl/reflective_sensor_conditioner_top_macros.svh
// assertion macros for the conditioner top level
`ifndef REFLECTIVE_SENSOR_CONDITIONER_TOP_MACROS_SVH
`define REFLECTIVE_SENSOR_CONDITIONER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define RSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define RSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rsc_pkg.sv
package rsc_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 16;
  localparam int LEVEL_W    = 10;
  localparam int ALPHA_W    = 17;
  localparam int DZ_W       = 10;
  localparam int SMOOTH_W   = 16;
  localparam int CNT_W      = 4;
  localparam int LEVEL_FRAC = 6;
  localparam int NORM_SHIFT = 9;
  localparam int DZ_SHIFT   = 15;
  localparam int ALPHA_FRAC = 16;

  localparam int SAMPLES_PER_GROUP_DEF = 16;

  localparam int ONE_Q15   = 32768;
  localparam int ALPHA_ONE = 65536;
  localparam int DZ_SCALE  = 1000;

  // deadband limit dz*32768/1000 as (dz*2147484) >> 16, exact for every 10-bit dz
  localparam int                   DZ_RECIP_W  = 22;
  localparam logic [DZ_RECIP_W-1:0] DZ_RECIP   = 22'd2147484;
  localparam int                   DZ_RECIP_SH = 16;

  // restoring divider for the normalising step
  localparam int DIV_NUM_W  = SUM_W + NORM_SHIFT;
  localparam int DIV_DEN_W  = LEVEL_W;
  localparam int DIV_STEPS  = DIV_NUM_W;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ALPHA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd3;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 10'd0;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 10'd1023;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 17'd6554;
  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST = 10'd10;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_NORM,
    ST_NORM_TAKE,
    ST_MUL,
    ST_SMOOTH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc;
    logic grp_end;
    logic div_step;
    logic norm_take;
    logic lim_take;
    logic smooth;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic div_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

### hw/rtl/rsc_in_if.sv
interface rsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [rsc_pkg::SAMPLE_W-1:0]  adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

### hw/rtl/rsc_out_if.sv
interface rsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rsc_pkg::SUM_W-1:0]     raw_average;
  logic [rsc_pkg::SMOOTH_W-1:0]  smooth_level;
  logic                          send;

  modport source (output valid, output raw_average, output smooth_level, output send,
                  input ready);
  modport sink   (input valid, input raw_average, input smooth_level, input send,
                  output ready);
endinterface

### hw/rtl/rsc_ctrl.sv
module rsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsc_pkg::ctrl_sts_t sts,
  output rsc_pkg::ctrl_cmd_t cmd
);
  import rsc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC: begin
        if (in_valid && sts.last_sample) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (sts.div_last) begin
          state_nxt = ST_NORM_TAKE;
        end
      end
      ST_NORM_TAKE: state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_SMOOTH;
      ST_SMOOTH:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_ACC: begin
        in_ready    = 1'b1;
        cmd.acc     = in_valid;
        cmd.grp_end = in_valid && sts.last_sample;
      end
      ST_NORM:      cmd.div_step  = 1'b1;
      ST_NORM_TAKE: cmd.norm_take = 1'b1;
      ST_MUL:       cmd.lim_take  = 1'b1;
      ST_SMOOTH:    cmd.smooth    = 1'b1;
      ST_OUT:       cmd.out_load  = sts.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

### hw/rtl/rsc_datapath.sv
module rsc_datapath #(
  parameter int SAMPLES_PER_GROUP = rsc_pkg::SAMPLES_PER_GROUP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rsc_pkg::ctrl_cmd_t              cmd,
  output rsc_pkg::ctrl_sts_t              sts,
  input  logic [rsc_pkg::SAMPLE_W-1:0]    adc_sample,
  input  logic                            cfg_we,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rsc_pkg::SUM_W-1:0]       raw_average,
  output logic [rsc_pkg::SMOOTH_W-1:0]    smooth_level,
  output logic                            send
);
  import rsc_pkg::*;

  localparam int CNT_P1 = CNT_W + 1;
  localparam int NS_W   = SMOOTH_W + 4;
  localparam int PROD_W = (SMOOTH_W + 1) + (ALPHA_W + 1);
  localparam int STEP_W = PROD_W - ALPHA_FRAC;
  localparam int LIMP_W = DZ_W + DZ_RECIP_W;

  localparam logic [CNT_W:0]          SPG_C     = CNT_P1'(SAMPLES_PER_GROUP);
  localparam logic [DIV_STEP_W-1:0]   STEP_LAST = DIV_STEP_W'(DIV_STEPS - 1);
  localparam logic [DIV_NUM_W-1:0]    NORM_MAX  = DIV_NUM_W'(ONE_Q15);
  localparam logic [SMOOTH_W-1:0]     ONE_S     = SMOOTH_W'(ONE_Q15);
  localparam logic [ALPHA_W-1:0]      ALPHA_MAX = ALPHA_W'(ALPHA_ONE);
  localparam logic signed [NS_W-1:0]  NS_ONE    = NS_W'(ONE_Q15);

  // config registers
  logic [LEVEL_W-1:0] threshold_r;
  logic [LEVEL_W-1:0] max_level_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [DZ_W-1:0]    dead_zone_r;

  // accumulator
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   grp_sum_r;
  logic [SUM_W-1:0]   sum_nxt;

  // divider
  logic [DIV_NUM_W-1:0]  dvd_r;
  logic [DIV_DEN_W-1:0]  den_r;
  logic [DIV_DEN_W-1:0]  rem_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [DIV_DEN_W:0]    rem_sh;
  logic [DIV_DEN_W:0]    rem_sub;
  logic                  rem_ge;

  // smoother
  logic [SMOOTH_W-1:0]       norm_r;
  logic [SMOOTH_W-1:0]       limit_r;
  logic [SMOOTH_W-1:0]       smoothed_r;
  logic [SMOOTH_W-1:0]       last_rep_r;
  logic                      first_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic [SUM_W-1:0]          th6;
  logic [SUM_W-1:0]          lvl_diff;
  logic [DIV_DEN_W-1:0]      span;
  logic [LIMP_W-1:0]         lim_prod;
  logic signed [SMOOTH_W:0]  delta;
  logic [ALPHA_W-1:0]        alpha_sat;
  logic signed [STEP_W-1:0]  adj;
  logic signed [NS_W-1:0]    ns;
  logic [SMOOTH_W-1:0]       ns_clamped;
  logic [SMOOTH_W-1:0]       diffabs;
  logic                      send_nxt;

  logic                      out_valid_r;
  logic [SUM_W-1:0]          raw_average_r;
  logic [SMOOTH_W-1:0]       smooth_level_r;
  logic                      send_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      max_level_r <= MAX_LEVEL_RST;
      alpha_r     <= ALPHA_RST;
      dead_zone_r <= DEAD_ZONE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_THRESHOLD: threshold_r <= cfg_data[LEVEL_W-1:0];
        CFG_MAX_LEVEL: max_level_r <= cfg_data[LEVEL_W-1:0];
        CFG_ALPHA:     alpha_r     <= cfg_data[ALPHA_W-1:0];
        CFG_DEAD_ZONE: dead_zone_r <= cfg_data[DZ_W-1:0];
        default:       threshold_r <= threshold_r;
      endcase
    end
  end

  assign sum_nxt         = sum_r + SUM_W'(adc_sample);
  assign sts.last_sample = ({1'b0, cnt_r} + 1'b1) >= SPG_C;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.acc) begin
      if (cmd.grp_end) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // level offset and span for the normalising divide
  assign th6      = {threshold_r, {LEVEL_FRAC{1'b0}}};
  assign lvl_diff = sum_nxt - th6;
  assign span     = (max_level_r > threshold_r) ? (max_level_r - threshold_r)
                                                 : DIV_DEN_W'(1);

  // one quotient bit per step, quotient shifts into the dividend register
  assign rem_sh  = {rem_r, dvd_r[DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign rem_ge  = rem_sh >= {1'b0, den_r};
  assign sts.div_last = step_r == STEP_LAST;

  always_ff @(posedge clk) begin
    if (cmd.grp_end) begin
      grp_sum_r <= sum_nxt;
      dvd_r     <= (sum_nxt > th6) ? {lvl_diff, {NORM_SHIFT{1'b0}}} : '0;
      den_r     <= span;
      rem_r     <= '0;
      step_r    <= '0;
    end else if (cmd.norm_take) begin
      norm_r <= (dvd_r > NORM_MAX) ? ONE_S : dvd_r[SMOOTH_W-1:0];
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[DIV_NUM_W-2:0], rem_ge};
      rem_r  <= rem_ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      step_r <= step_r + 1'b1;
    end
  end

  // deadband limit by reciprocal multiply
  assign lim_prod  = dead_zone_r * DZ_RECIP;
  assign delta     = $signed({1'b0, norm_r}) - $signed({1'b0, smoothed_r});
  assign alpha_sat = (alpha_r > ALPHA_MAX) ? ALPHA_MAX : alpha_r;

  always_ff @(posedge clk) begin
    if (cmd.lim_take) begin
      limit_r <= lim_prod[DZ_RECIP_SH +: SMOOTH_W];
      prod_r  <= delta * $signed({1'b0, alpha_sat});
    end
  end

  // arithmetic shift is the floor of the divide by 65536
  assign adj = prod_r[PROD_W-1:ALPHA_FRAC];
  assign ns  = $signed({4'b0000, smoothed_r}) + NS_W'(adj);
  assign ns_clamped = (ns < 0) ? '0 : ((ns > NS_ONE) ? ONE_S : ns[SMOOTH_W-1:0]);

  assign diffabs  = (smoothed_r > last_rep_r) ? (smoothed_r - last_rep_r)
                                               : (last_rep_r - smoothed_r);
  assign send_nxt = (diffabs > limit_r) || (smoothed_r == '0) || (smoothed_r == ONE_S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= '0;
      last_rep_r <= '0;
      first_r    <= 1'b1;
    end else if (cmd.smooth) begin
      if (first_r) begin
        smoothed_r <= norm_r;
        last_rep_r <= '0;
        first_r    <= 1'b0;
      end else begin
        smoothed_r <= ns_clamped;
      end
    end else if (cmd.out_load && send_nxt) begin
      last_rep_r <= smoothed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      raw_average_r  <= grp_sum_r;
      smooth_level_r <= smoothed_r;
      send_r         <= send_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign raw_average  = raw_average_r;
  assign smooth_level = smooth_level_r;
  assign send         = send_r;

endmodule

### hw/rtl/reflective_sensor_conditioner_top.sv
// samples that do not close a group: one per cycle, accepted in the cycle they arrive
// a group-closing sample: 25-step divide, quotient take, multiply and smoother update, then
// the result load once the output register is free; input is held off until that load
// results sit in an output register; the next group is accepted while one waits
// synchronous active-low reset: config to defaults, accumulator, smoother and first-group flag
`include "reflective_sensor_conditioner_top_macros.svh"

module reflective_sensor_conditioner_top #(
  parameter int SAMPLES_PER_GROUP = rsc_pkg::SAMPLES_PER_GROUP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rsc_in_if.sink                          in_if,
  rsc_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rsc_pkg::*;

  localparam logic [SMOOTH_W-1:0] ONE_S = SMOOTH_W'(ONE_Q15);

  // control to datapath: one strobe per operation of the group sequence
  ctrl_cmd_t cmd;
  // datapath to control: end of group, last divider step, output slot free
  ctrl_sts_t sts;

  // result sitting at either end of the unit range
  logic      out_at_end;

  // sequencer: accumulate, normalising divide, quotient take,
  // multiply with deadband limit, smoother update, result load
  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // accumulator, restoring divider, 17x18 multiplier, output register
  rsc_datapath #(
    .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .adc_sample   (in_if.adc_sample),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .raw_average  (out_if.raw_average),
    .smooth_level (out_if.smooth_level),
    .send         (out_if.send)
  );

  assign out_at_end = (out_if.smooth_level == '0) || (out_if.smooth_level == ONE_S);

  // smoothed level never leaves the unit range
  `RSC_ASSERT_NOW(a_smooth_range, out_if.valid, out_if.smooth_level <= ONE_S, "smooth above one")

  // the end points of the range are always reported
  `RSC_ASSERT_NOW(a_send_ends, out_if.valid && out_at_end, out_if.send, "end point not sent")

  // no sample is taken while the divider runs
  `RSC_ASSERT_NOW(a_busy_no_input, cmd.div_step, !in_if.ready, "input accepted during divide")

  // loading a result always raises valid on the next cycle
  `RSC_ASSERT_NEXT(a_load_valid, cmd.out_load, out_if.valid, "result load lost")

endmodule

### test/reflective_sensor_conditioner_top_tb.sv
`timescale 1ns / 100ps

module reflective_sensor_conditioner_top_tb;
  import rsc_pkg::*;

  localparam int GROUP_LEN        = SAMPLES_PER_GROUP_DEF;
  // settle time after the last result is in, long enough for any work still in flight
  localparam int SETTLE_CYCLES    = 64;
  localparam int LONG_HOLD        = 400;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int RANDOM_PHASES    = 8;
  localparam int GROUPS_PER_PHASE = 7;
  localparam int PRESSURE_PHASE   = 2;

  // one result as it leaves the block
  typedef struct packed {
    logic [SUM_W-1:0]    raw_average;
    logic [SMOOTH_W-1:0] smooth_level;
    logic                send;
  } level_report_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  // one line of the directed table: a register write, or a run of equal samples
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [SAMPLE_W-1:0]   sample;
    logic [4:0]            reps;
    logic                  pinned;
    level_report_t         want;
  } stim_row_t;

  // pinned rows carry the result of the group that their last sample closes
  localparam stim_row_t PLAN [0:15] = '{
    // first group after reset, all zero: smoother loaded, zero always goes out
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'd0,     5'd16, 1'b1, '{16'd0,     16'd0,     1'b1}},
    // full-scale group, clamped to one, default weight moves a tenth of the way
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'd4095,  5'd16, 1'b1, '{16'd65520, 16'd3277,  1'b1}},
    // alternating bit patterns over one group
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'hAAA,   5'd8,  1'b0, '0},
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'h555,   5'd8,  1'b0, '0},
    // weight register above one behaves as one
    '{ROW_CFG,    CFG_ALPHA,     17'h1FFFF, 12'd0, 5'd0,  1'b0, '0},
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'd4095,  5'd16, 1'b1, '{16'd65520, 16'd32768, 1'b1}},
    // full-scale level at or below threshold: span of one
    '{ROW_CFG,    CFG_THRESHOLD, 17'd600,  12'd0,  5'd0,  1'b0, '0},
    '{ROW_CFG,    CFG_MAX_LEVEL, 17'd500,  12'd0,  5'd0,  1'b0, '0},
    // exactly on the threshold gives zero, just above it saturates
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'd2400,  5'd16, 1'b1, '{16'd38400, 16'd0,     1'b1}},
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'd2404,  5'd16, 1'b1, '{16'd38464, 16'd32768, 1'b1}},
    // deadband over full scale: only zero and one can go out
    '{ROW_CFG,    CFG_THRESHOLD, 17'd0,    12'd0,  5'd0,  1'b0, '0},
    '{ROW_CFG,    CFG_MAX_LEVEL, 17'd1023, 12'd0,  5'd0,  1'b0, '0},
    '{ROW_CFG,    CFG_ALPHA,     17'd32768, 12'd0, 5'd0,  1'b0, '0},
    '{ROW_CFG,    CFG_DEAD_ZONE, 17'd1023, 12'd0,  5'd0,  1'b0, '0},
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'd2048,  5'd16, 1'b0, '0},
    '{ROW_SAMPLE, CFG_THRESHOLD, 17'd0, 12'd2048,  5'd16, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rsc_in_if  sample_ch ();
  rsc_out_if report_ch ();

  reflective_sensor_conditioner_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (sample_ch),
    .out_if   (report_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // predictor copy of the registers
  logic [LEVEL_W-1:0]  lvl_floor;
  logic [LEVEL_W-1:0]  lvl_full;
  logic [ALPHA_W-1:0]  gain;
  logic [DZ_W-1:0]     deadband;

  // predictor copy of the state
  logic [SUM_W-1:0]    acc_sum;
  int unsigned         acc_count;
  logic [SMOOTH_W-1:0] ema;
  logic [SMOOTH_W-1:0] last_sent;
  bit                  fresh_start;

  level_report_t       due_reports [$];
  int unsigned         mismatches;
  int unsigned         quiet_cycles;

  // shared between the stimulus, the result sink and the scoreboard
  bit                  src_jitter;
  bit                  snk_jitter;
  bit                  calm;
  bit                  hold_req;
  bit                  pin_on;
  level_report_t       pin_report;

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // reset from time zero, released on a falling edge; every input known from time zero
  initial begin : reset_seq
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_data             = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.adc_sample = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  // predictor: one item in, maybe one result out
  function automatic bit take_sample(input logic [SAMPLE_W-1:0] s,
                                     output level_report_t rep);
    logic [SUM_W-1:0] grp;
    longint excess, span, norm, delta, next_ema, limit, spread;
    rep = '0;
    acc_sum = acc_sum + SUM_W'(s);
    if (acc_count != GROUP_LEN - 1) begin
      acc_count++;
      return 1'b0;
    end
    grp       = acc_sum;
    acc_sum   = '0;
    acc_count = 0;

    // level above threshold, scaled against the span into q1.15
    excess = longint'(grp) - (longint'(lvl_floor) << LEVEL_FRAC);
    if (excess <= 0) begin
      norm = 0;
    end else begin
      span = (lvl_full > lvl_floor) ? longint'(lvl_full - lvl_floor) : 1;
      norm = (excess << NORM_SHIFT) / span;
      if (norm > ONE_Q15) norm = ONE_Q15;
    end

    // first group loads the smoother, later ones step towards norm, floored
    if (fresh_start) begin
      next_ema    = norm;
      last_sent   = '0;
      fresh_start = 1'b0;
    end else begin
      delta    = norm - longint'(ema);
      next_ema = longint'(ema) +
                 ((delta * ((gain > ALPHA_ONE) ? ALPHA_ONE : longint'(gain))) >>> ALPHA_FRAC);
      if (next_ema < 0) next_ema = 0;
      if (next_ema > ONE_Q15) next_ema = ONE_Q15;
    end
    ema = next_ema[SMOOTH_W-1:0];

    // deadband in thousandths of full scale, not clamped
    limit  = (longint'(deadband) << DZ_SHIFT) / DZ_SCALE;
    spread = longint'(ema) - longint'(last_sent);
    if (spread < 0) spread = -spread;

    rep.raw_average  = grp;
    rep.smooth_level = ema;
    rep.send         = (spread > limit) || (ema == 0) || (ema == ONE_Q15);
    if (rep.send) last_sent = ema;
    return 1'b1;
  endfunction

  // scoreboard: follows reset and register writes, predicts on each accepted item,
  // checks each accepted result against the oldest expectation
  always @(posedge clk) begin : scoreboard
    level_report_t rep;
    level_report_t got;
    level_report_t want;
    if (!rst_n) begin
      lvl_floor   = THRESHOLD_RST;
      lvl_full    = MAX_LEVEL_RST;
      gain        = ALPHA_RST;
      deadband    = DEAD_ZONE_RST;
      acc_sum     = '0;
      acc_count   = 0;
      ema         = '0;
      last_sent   = '0;
      fresh_start = 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_THRESHOLD: lvl_floor = cfg_data[LEVEL_W-1:0];
          CFG_MAX_LEVEL: lvl_full  = cfg_data[LEVEL_W-1:0];
          CFG_ALPHA:     gain      = cfg_data;
          CFG_DEAD_ZONE: deadband  = cfg_data[DZ_W-1:0];
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        if (take_sample(sample_ch.adc_sample, rep)) begin
          // directed rows with a hand-worked result replace the prediction
          if (pin_on) begin
            rep    = pin_report;
            pin_on = 1'b0;
          end
          due_reports.push_back(rep);
        end
      end
      if (report_ch.valid && report_ch.ready) begin
        got = '{report_ch.raw_average, report_ch.smooth_level, report_ch.send};
        if (due_reports.size() == 0) begin
          flag_mismatch($sformatf("result with nothing due: raw %0d smooth %0d send %0b",
                                  got.raw_average, got.smooth_level, got.send));
        end else begin
          want = due_reports.pop_front();
          if (got.raw_average !== want.raw_average)
            flag_mismatch($sformatf("raw_average %0d, wanted %0d",
                                    got.raw_average, want.raw_average));
          if (got.smooth_level !== want.smooth_level)
            flag_mismatch($sformatf("smooth_level %0d, wanted %0d",
                                    got.smooth_level, want.smooth_level));
          if (got.send !== want.send)
            flag_mismatch($sformatf("send %0b, wanted %0b", got.send, want.send));
        end
      end
    end
  end

  // watchdog: too many cycles in a row with no item moving on either side
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (report_ch.valid && report_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result sink: short random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left      = 0;
    report_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        report_ch.ready <= 1'b0;
      end else if (hold_req) begin
        // long hold so the output register fills and the input backs up
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        report_ch.ready <= 1'b0;
      end else if (snk_jitter && !calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 8);
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
      end
    end
  end

  // offer one item, at times with a random gap in front of it, and wait for the handshake
  task automatic push_sample(input logic [SAMPLE_W-1:0] value, input bit pin,
                             input level_report_t pin_rep);
    int gap;
    if (src_jitter && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_ch.valid      <= 1'b1;
    sample_ch.adc_sample <= value;
    pin_on     = pin;
    pin_report = pin_rep;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
  endtask

  // sender goes quiet until every result is in and the block has nothing in flight
  task automatic drain();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // level register value, with the extremes favoured
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // one full group; sample level is sample/4, so centres sit near the register levels
  task automatic push_group(input logic [LEVEL_W-1:0] th, input logic [LEVEL_W-1:0] mx);
    int mode, centre, v;
    logic [SAMPLE_W-1:0] s;
    mode   = $urandom_range(0, 3);
    centre = (mode == 1) ? int'(th) * 4 : int'(mx) * 4;
    for (int i = 0; i < GROUP_LEN; i++) begin
      case (mode)
        0: s = SAMPLE_W'($urandom_range(0, 4095));
        1, 2: begin
          v = centre + int'($urandom_range(0, 80)) - 40;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          s = SAMPLE_W'(v);
        end
        default: s = $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : '0;
      endcase
      push_sample(s, 1'b0, '0);
    end
  endtask

  // one random setting of all four registers, then a run of groups
  task automatic run_phase(input bit pressure);
    logic [LEVEL_W-1:0] th, mx;
    logic [ALPHA_W-1:0] a;
    logic [DZ_W-1:0]    dz;
    int                 m;
    drain();
    th = pick_level();
    if ($urandom_range(0, 3) == 0) begin
      mx = pick_level();
    end else begin
      m  = int'(th) + int'($urandom_range(1, 300));
      mx = (m > 1023) ? '1 : LEVEL_W'(m);
    end
    case ($urandom_range(0, 5))
      0:       a = '0;
      1:       a = ALPHA_W'(ALPHA_ONE);
      2:       a = '1;
      3:       a = ALPHA_W'($urandom_range(0, ALPHA_ONE));
      default: a = ALPHA_W'($urandom_range(500, 20000));
    endcase
    case ($urandom_range(0, 4))
      0:       dz = '0;
      1:       dz = DZ_W'(DZ_SCALE);
      2:       dz = '1;
      default: dz = DZ_W'($urandom_range(1, 60));
    endcase
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(th));
    write_reg(CFG_MAX_LEVEL, CFG_DATA_W'(mx));
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_DEAD_ZONE, CFG_DATA_W'(dz));
    // some phases run with no idling at all on one side or both
    src_jitter = $urandom_range(0, 3) != 0;
    snk_jitter = $urandom_range(0, 3) != 0;
    if (pressure) begin
      src_jitter = 1'b0;
      hold_req   = 1'b1;
    end
    repeat (GROUPS_PER_PHASE) push_group(th, mx);
  endtask

  // directed table first, then random phases, the last one without idling
  initial begin : stimulus
    src_jitter = 1'b1;
    snk_jitter = 1'b1;
    calm       = 1'b0;
    hold_req   = 1'b0;
    pin_on     = 1'b0;
    pin_report = '0;
    mismatches = 0;
    quiet_cycles = 0;
    wait (rst_n === 1'b1);

    for (int r = 0; r < $size(PLAN); r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        drain();
        write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
      end else begin
        for (int k = 0; k < PLAN[r].reps; k++)
          push_sample(PLAN[r].sample, PLAN[r].pinned && (k == PLAN[r].reps - 1),
                      PLAN[r].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == RANDOM_PHASES - 1);
      run_phase(p == PRESSURE_PHASE);
    end

    drain();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
